// ===== rtl/qau_pkg.sv =====
// Shared types, constants and helper functions of the quaternion arithmetic unit.
package qau_pkg;

  typedef enum logic [3:0] {
    OpMul   = 4'd0,
    OpAdd   = 4'd1,
    OpSub   = 4'd2,
    OpAddS  = 4'd3,
    OpSubS  = 4'd4,
    OpScale = 4'd5,
    OpNeg   = 4'd6,
    OpDot   = 4'd7,
    OpNorm  = 4'd8,
    OpInv   = 4'd9
  } op_e;

  localparam int unsigned SumW     = 66;
  localparam int unsigned QuotW    = 31;
  localparam int unsigned RootW    = 62;
  localparam int unsigned NumSteps = 31;

  localparam logic signed [31:0] QMax = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] QMin = 32'sh8000_0000;

  typedef logic signed [31:0] q_t;

  typedef struct {
    op_e              op;
    q_t               er [4];
    q_t               esc;
    logic [63:0]      s;
    logic             carry;
    logic             zero;
    logic [63:0]      dr [4];
    logic [QuotW-1:0] dq [4];
    logic             ovf [4];
    logic             neg [4];
    logic             maxm [4];
    logic [RootW-1:0] srem;
    logic [RootW-1:0] sroot;
    logic             big;
  } it_t;

  function automatic q_t sat_q(input logic signed [SumW-1:0] v);
    q_t r;
    if (v > SumW'(QMax)) begin
      r = QMax;
    end else if (v < SumW'(QMin)) begin
      r = QMin;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // term t of Hamilton product component c enters with a minus sign
  function automatic logic mul_neg(input logic [1:0] c, input logic [1:0] t);
    logic [3:0] m;
    unique case (c)
      2'd0: m = 4'b1110;
      2'd1: m = 4'b1000;
      2'd2: m = 4'b0010;
      2'd3: m = 4'b0100;
    endcase
    return m[t];
  endfunction

endpackage

// ===== rtl/qau_in_if.sv =====
// Operand channel of the quaternion arithmetic unit.
interface qau_in_if;
  logic              valid;
  logic              ready;
  logic [3:0]        op;
  logic signed [31:0] a_w;
  logic signed [31:0] a_x;
  logic signed [31:0] a_y;
  logic signed [31:0] a_z;
  logic signed [31:0] b_w;
  logic signed [31:0] b_x;
  logic signed [31:0] b_y;
  logic signed [31:0] b_z;
  logic signed [31:0] scalar_in;

  modport source (
    output valid, op, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, scalar_in,
    input  ready
  );
  modport sink (
    input  valid, op, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, scalar_in,
    output ready
  );
endinterface

// ===== rtl/qau_out_if.sv =====
// Result channel of the quaternion arithmetic unit.
interface qau_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] r_w;
  logic signed [31:0] r_x;
  logic signed [31:0] r_y;
  logic signed [31:0] r_z;
  logic signed [31:0] scalar_out;
  logic               zero_error;

  modport source (
    output valid, r_w, r_x, r_y, r_z, scalar_out, zero_error,
    input  ready
  );
  modport sink (
    input  valid, r_w, r_x, r_y, r_z, scalar_out, zero_error,
    output ready
  );
endinterface

// ===== rtl/quaternion_arithmetic_unit.sv =====
// Top level of the quaternion arithmetic unit: a Q16.16 pipeline with saturating results.
//
//   channel  direction  handshake      payload
//   req_i    in         valid/ready    op, a_w..a_z, b_w..b_z, scalar_in
//   rsp_o    out        valid/ready    r_w..r_z, scalar_out, zero_error
//
// One transaction per cycle while rsp_o does not stall; a result passes through every stage
// to rsp_o and waits there while rsp_o stalls.
// Depth is set by the 31 square root and restoring division stages, one bit per stage.
// Reset clears the valid bit of every stage; the data registers are not reset.
// A full stage holds while the one after it is full and stalled; empty stages close up,
// so req_i.ready falls only when every stage holds a transaction and rsp_o stalls.
module quaternion_arithmetic_unit (
  input  logic     clk_i,
  input  logic     rst_ni,
  qau_in_if.sink   req_i,
  qau_out_if.source rsp_o
);

  localparam int unsigned NS = qau_pkg::NumSteps;

  typedef struct {
    qau_pkg::op_e       op;
    logic signed [63:0] p [4][4];
    qau_pkg::q_t        e [4];
    logic [31:0]        mag [4];
    logic               sgn [4];
  } s1_t;

  typedef struct {
    qau_pkg::op_e       op;
    logic signed [64:0] ps [4][2];
    qau_pkg::q_t        e [4];
    logic [31:0]        mag [4];
    logic               sgn [4];
  } s2_t;

  typedef struct {
    qau_pkg::op_e       op;
    logic signed [65:0] tot [4];
    qau_pkg::q_t        e [4];
    logic [31:0]        mag [4];
    logic               sgn [4];
  } s3_t;

  typedef struct {
    qau_pkg::op_e op;
    qau_pkg::q_t  er [4];
    qau_pkg::q_t  esc;
    qau_pkg::q_t  inv [4];
    logic         zero;
    qau_pkg::q_t  sq;
  } rd_t;

  typedef struct {
    qau_pkg::q_t r [4];
    qau_pkg::q_t sc;
    logic        zerr;
  } out_t;

  logic en1, en2, en3, en4, en_r, en_o;
  logic [NS-1:0] en_it;
  logic [NS:0]   vit;
  logic v1_q, v2_q, v3_q, v4_q, vr_q, vo_q;

  s1_t s1_d, s1_q;
  s2_t s2_d, s2_q;
  s3_t s3_d, s3_q;
  qau_pkg::it_t it_d;
  qau_pkg::it_t it_q_seed;
  qau_pkg::it_t it_q [NS+1];
  rd_t  rd_d, rd_q;
  out_t o_d, o_q;

  // handshake and stage enables
  assign en_o = !vo_q || rsp_o.ready;
  assign en_r = !vr_q || en_o;
  assign en4  = !vit[0] || en_it[0];
  assign en3  = !v3_q || en4;
  assign en2  = !v2_q || en3;
  assign en1  = !v1_q || en2;
  assign req_i.ready = en1;

  // stage 1: operand select, products, add, subtract and negate ops
  qau_pkg::op_e       op_in;
  logic signed [31:0] a [4];
  logic signed [31:0] b [4];
  logic signed [31:0] y [4][4];
  logic signed [32:0] sum33 [4];

  always_comb begin
    op_in = qau_pkg::op_e'(req_i.op);
    a[0] = req_i.a_w; a[1] = req_i.a_x; a[2] = req_i.a_y; a[3] = req_i.a_z;
    b[0] = req_i.b_w; b[1] = req_i.b_x; b[2] = req_i.b_y; b[3] = req_i.b_z;
    s1_d.op = op_in;
    for (int c = 0; c < 4; c++) begin
      for (int t = 0; t < 4; t++) begin
        unique case (op_in)
          qau_pkg::OpMul:   y[c][t] = b[2'(c) ^ 2'(t)];
          qau_pkg::OpScale: y[c][t] = (c == t) ? req_i.scalar_in : 32'sd0;
          qau_pkg::OpDot:   y[c][t] = (c == 0) ? b[t] : 32'sd0;
          qau_pkg::OpNorm,
          qau_pkg::OpInv:   y[c][t] = (c == 0) ? a[t] : 32'sd0;
          default:          y[c][t] = 32'sd0;
        endcase
        s1_d.p[c][t] = a[t] * y[c][t];
      end
    end
    for (int i = 0; i < 4; i++) begin
      unique case (op_in)
        qau_pkg::OpAdd:  sum33[i] = 33'(a[i]) + 33'(b[i]);
        qau_pkg::OpSub:  sum33[i] = 33'(a[i]) - 33'(b[i]);
        qau_pkg::OpAddS: sum33[i] = 33'(a[i]) + 33'(req_i.scalar_in);
        qau_pkg::OpSubS: sum33[i] = 33'(a[i]) - 33'(req_i.scalar_in);
        qau_pkg::OpNeg:  sum33[i] = 33'sd0 - 33'(a[i]);
        default:         sum33[i] = 33'sd0;
      endcase
      s1_d.e[i]   = qau_pkg::sat_q(qau_pkg::SumW'(sum33[i]));
      s1_d.mag[i] = a[i][31] ? 32'(-a[i]) : 32'(a[i]);
      s1_d.sgn[i] = a[i][31];
    end
  end

  // stage 2: signed pair sums
  logic signed [64:0] pa [4][4];
  logic               ng [4][4];

  always_comb begin
    s2_d.op  = s1_q.op;
    s2_d.e   = s1_q.e;
    s2_d.mag = s1_q.mag;
    s2_d.sgn = s1_q.sgn;
    for (int c = 0; c < 4; c++) begin
      for (int t = 0; t < 4; t++) begin
        pa[c][t] = 65'(s1_q.p[c][t]);
        ng[c][t] = (s1_q.op == qau_pkg::OpMul) && qau_pkg::mul_neg(2'(c), 2'(t));
      end
      for (int k = 0; k < 2; k++) begin
        unique case ({ng[c][2*k], ng[c][2*k+1]})
          2'b00: s2_d.ps[c][k] = pa[c][2*k] + pa[c][2*k+1];
          2'b01: s2_d.ps[c][k] = pa[c][2*k] - pa[c][2*k+1];
          2'b10: s2_d.ps[c][k] = pa[c][2*k+1] - pa[c][2*k];
          2'b11: s2_d.ps[c][k] = -(pa[c][2*k] + pa[c][2*k+1]);
        endcase
      end
    end
  end

  // stage 3: component sums
  always_comb begin
    s3_d.op  = s2_q.op;
    s3_d.e   = s2_q.e;
    s3_d.mag = s2_q.mag;
    s3_d.sgn = s2_q.sgn;
    for (int c = 0; c < 4; c++) begin
      s3_d.tot[c] = 66'(s2_q.ps[c][0]) + 66'(s2_q.ps[c][1]);
    end
  end

  // stage 4: round products, seed square root and divisions
  logic signed [65:0] rnd [4];
  qau_pkg::q_t        rs [4];
  logic [64:0]        sq_sum;

  always_comb begin
    sq_sum = s3_q.tot[0][64:0];
    for (int c = 0; c < 4; c++) begin
      rnd[c] = (s3_q.tot[c] + 66'sd32768) >>> 16;
      rs[c]  = qau_pkg::sat_q(rnd[c]);
    end
    it_d.op = s3_q.op;
    unique case (s3_q.op)
      qau_pkg::OpMul,
      qau_pkg::OpScale: begin
        it_d.er  = rs;
        it_d.esc = 32'sd0;
      end
      qau_pkg::OpDot: begin
        it_d.er  = '{default: 32'sd0};
        it_d.esc = rs[0];
      end
      qau_pkg::OpAdd,
      qau_pkg::OpSub,
      qau_pkg::OpAddS,
      qau_pkg::OpSubS,
      qau_pkg::OpNeg: begin
        it_d.er  = s3_q.e;
        it_d.esc = 32'sd0;
      end
      default: begin
        it_d.er  = '{default: 32'sd0};
        it_d.esc = 32'sd0;
      end
    endcase
    it_d.s     = sq_sum[63:0];
    it_d.carry = sq_sum[64];
    it_d.zero  = (sq_sum == 65'd0);
    it_d.big   = |sq_sum[64:62];
    it_d.srem  = sq_sum[61:0];
    it_d.sroot = '0;
    for (int c = 0; c < 4; c++) begin
      it_d.dr[c]   = 64'({s3_q.mag[c], 1'b0});
      it_d.dq[c]   = '0;
      it_d.ovf[c]  = 65'({s3_q.mag[c], 1'b0}) >= sq_sum;
      it_d.neg[c]  = s3_q.sgn[c] ^ (c != 0);
      it_d.maxm[c] = s3_q.mag[c][31];
    end
  end

  // stages 5 to 35: one root bit and one bit of each quotient per stage
  assign vit[0]  = v4_q;
  assign it_q[0] = it_q_seed;

  for (genvar j = 0; j < NS; j++) begin : g_step
    if (j == NS - 1) begin : g_last
      assign en_it[j] = !vit[j+1] || en_r;
    end else begin : g_mid
      assign en_it[j] = !vit[j+1] || en_it[j+1];
    end
    qau_step #(
      .Step (j)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en_it[j]),
      .valid_i (vit[j]),
      .data_i  (it_q[j]),
      .valid_o (vit[j+1]),
      .data_o  (it_q[j+1])
    );
  end

  // stage 36: round quotients and root, apply sign and saturate
  logic [31:0] qr [4];
  logic [31:0] qs [4];
  logic        up [4];
  logic [31:0] rr;

  always_comb begin
    rd_d.op   = it_q[NS].op;
    rd_d.er   = it_q[NS].er;
    rd_d.esc  = it_q[NS].esc;
    rd_d.zero = it_q[NS].zero && !it_q[NS].carry;
    for (int c = 0; c < 4; c++) begin
      up[c] = {it_q[NS].dr[c], 1'b0} >= {1'b0, it_q[NS].s};
      qr[c] = {1'b0, it_q[NS].dq[c]} + 32'(up[c]);
      qs[c] = it_q[NS].carry ? {31'd0, it_q[NS].maxm[c]} : qr[c];
      if (it_q[NS].ovf[c] && !it_q[NS].carry) begin
        rd_d.inv[c] = it_q[NS].neg[c] ? qau_pkg::QMin : qau_pkg::QMax;
      end else if (it_q[NS].neg[c]) begin
        rd_d.inv[c] = -$signed(qs[c]);
      end else begin
        rd_d.inv[c] = qs[c][31] ? qau_pkg::QMax : $signed(qs[c]);
      end
    end
    rr = it_q[NS].sroot[31:0] + 32'(it_q[NS].srem > it_q[NS].sroot);
    rd_d.sq = (it_q[NS].big || rr[31]) ? qau_pkg::QMax : $signed(rr);
  end

  // stage 37: output register
  always_comb begin
    unique case (rd_q.op)
      qau_pkg::OpNorm: begin
        o_d.r    = '{default: 32'sd0};
        o_d.sc   = rd_q.sq;
        o_d.zerr = 1'b0;
      end
      qau_pkg::OpInv: begin
        if (rd_q.zero) begin
          o_d.r = '{default: 32'sd0};
        end else begin
          o_d.r = rd_q.inv;
        end
        o_d.sc   = 32'sd0;
        o_d.zerr = rd_q.zero;
      end
      default: begin
        o_d.r    = rd_q.er;
        o_d.sc   = rd_q.esc;
        o_d.zerr = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      vr_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= req_i.valid;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
      if (en4) begin
        v4_q <= v3_q;
      end
      if (en_r) begin
        vr_q <= vit[NS];
      end
      if (en_o) begin
        vo_q <= vr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_q <= s1_d;
    end
    if (en2) begin
      s2_q <= s2_d;
    end
    if (en3) begin
      s3_q <= s3_d;
    end
    if (en4) begin
      it_q_seed <= it_d;
    end
    if (en_r) begin
      rd_q <= rd_d;
    end
    if (en_o) begin
      o_q <= o_d;
    end
  end

  assign rsp_o.valid      = vo_q;
  assign rsp_o.r_w        = o_q.r[0];
  assign rsp_o.r_x        = o_q.r[1];
  assign rsp_o.r_y        = o_q.r[2];
  assign rsp_o.r_z        = o_q.r[3];
  assign rsp_o.scalar_out = o_q.sc;
  assign rsp_o.zero_error = o_q.zerr;

  a_zero_err_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.zero_error |->
      rsp_o.r_w == 0 && rsp_o.r_x == 0 && rsp_o.r_y == 0 && rsp_o.r_z == 0 &&
      rsp_o.scalar_out == 0)
    else $error("zero norm transaction carries non-zero results");

  a_scalar_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.scalar_out != 0 |->
      rsp_o.r_w == 0 && rsp_o.r_x == 0 && rsp_o.r_y == 0 && rsp_o.r_z == 0)
    else $error("scalar and quaternion results both set");

  a_stage1_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && !en1 |=> v1_q && $stable(s1_q.op))
    else $error("stalled first stage dropped its transaction");

  a_full_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && v2_q && v3_q && (&vit) && vr_q && vo_q && !rsp_o.ready |-> !req_i.ready)
    else $error("full pipeline took a transaction while stalled");

endmodule

// ===== rtl/qau_step.sv =====
// One pipeline stage of the square root and the four divisions, one bit each.
module qau_step #(
  parameter int unsigned Step = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  qau_pkg::it_t  data_i,
  output logic          valid_o,
  output qau_pkg::it_t  data_o
);

  localparam int unsigned RW    = qau_pkg::RootW;
  localparam int unsigned QW    = qau_pkg::QuotW;
  localparam int unsigned Shift = 2 * (qau_pkg::NumSteps - 1 - Step);
  localparam logic [RW-1:0] One = 1;
  localparam logic [RW-1:0] Bit = One << Shift;

  logic         valid_q;
  qau_pkg::it_t data_d;
  qau_pkg::it_t data_q;
  logic [RW:0]  trial;
  logic [64:0]  r2 [4];

  always_comb begin
    data_d = data_i;
    trial  = {1'b0, data_i.sroot} + {1'b0, Bit};
    if ({1'b0, data_i.srem} >= trial) begin
      data_d.srem  = data_i.srem - trial[RW-1:0];
      data_d.sroot = (data_i.sroot >> 1) + Bit;
    end else begin
      data_d.sroot = data_i.sroot >> 1;
    end
    for (int c = 0; c < 4; c++) begin
      r2[c] = {data_i.dr[c], 1'b0};
      if (r2[c] >= {1'b0, data_i.s}) begin
        data_d.dr[c] = 64'(r2[c] - {1'b0, data_i.s});
        data_d.dq[c] = {data_i.dq[c][QW-2:0], 1'b1};
      end else begin
        data_d.dr[c] = r2[c][63:0];
        data_d.dq[c] = {data_i.dq[c][QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
